@@ rtl/ept_pkg.sv @@
// ----------------------------------------------------------------------------
// Rigid point transform package
// Shared widths, register indexes, payload types, CORDIC arctangent table and
// the operation list of the matrix rebuild sequencer.
// ----------------------------------------------------------------------------
package ept_pkg;

  // Coordinate width of every point, offset and result field (Q.8).
  localparam int COORD_WIDTH        = 24;
  // Default fraction bits of the sine, cosine and matrix values.
  localparam int TRIG_FRAC_BITS_DEF = 17;
  localparam int ANG_WIDTH          = 17;
  localparam int CFG_INDEX_WIDTH    = 3;
  localparam int CFG_DATA_WIDTH     = (COORD_WIDTH > ANG_WIDTH) ? COORD_WIDTH : ANG_WIDTH;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_YAW      = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PITCH    = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROLL     = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_X = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_Y = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_Z = 3'd5;

  // Angle constants in units of 1/128 degree.
  localparam logic signed [17:0] DEG360     = 18'sd46080;
  localparam logic signed [17:0] DEG180     = 18'sd23040;
  localparam logic signed [17:0] DEG90      = 18'sd11520;
  localparam logic signed [17:0] DEG360_NEG = -18'sd46080;
  localparam logic signed [17:0] DEG180_NEG = -18'sd23040;
  localparam logic signed [17:0] DEG90_NEG  = -18'sd11520;

  // CORDIC: 18 steps, Q4.30 datapath, angle in units of 2^-15 degree.
  localparam int                 CORDIC_STEPS = 18;
  localparam int                 CORDIC_W     = 34;
  localparam int                 CORDIC_ZW    = 26;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;

  // Matrix rebuild sequencer: operand sources, destinations and write modes.
  localparam int MAT_OPS = 14;

  localparam logic [2:0] SRC_CA = 3'd0;
  localparam logic [2:0] SRC_SA = 3'd1;
  localparam logic [2:0] SRC_CB = 3'd2;
  localparam logic [2:0] SRC_SB = 3'd3;
  localparam logic [2:0] SRC_CY = 3'd4;
  localparam logic [2:0] SRC_SY = 3'd5;
  localparam logic [2:0] SRC_TA = 3'd6;
  localparam logic [2:0] SRC_TB = 3'd7;

  localparam logic [3:0] DST_M00 = 4'd0;
  localparam logic [3:0] DST_M01 = 4'd1;
  localparam logic [3:0] DST_M02 = 4'd2;
  localparam logic [3:0] DST_M10 = 4'd3;
  localparam logic [3:0] DST_M11 = 4'd4;
  localparam logic [3:0] DST_M12 = 4'd5;
  localparam logic [3:0] DST_M20 = 4'd6;
  localparam logic [3:0] DST_M21 = 4'd7;
  localparam logic [3:0] DST_M22 = 4'd8;
  localparam logic [3:0] DST_TA  = 4'd9;
  localparam logic [3:0] DST_TB  = 4'd10;

  localparam logic [1:0] WB_SET = 2'd0;
  localparam logic [1:0] WB_ADD = 2'd1;
  localparam logic [1:0] WB_SUB = 2'd2;

  typedef struct packed {
    logic [2:0] src_a;
    logic [2:0] src_b;
    logic [3:0] dest;
    logic [1:0] mode;
  } mat_op_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          saturated;
  } result_t;

  // atan(2^-i) in units of 2^-15 degree.
  function automatic logic signed [CORDIC_ZW-1:0] cordic_atan(input logic [4:0] i);
    logic signed [CORDIC_ZW-1:0] v;
    case (i)
      5'd0:    v = 26'sd1474560;
      5'd1:    v = 26'sd870484;
      5'd2:    v = 26'sd459940;
      5'd3:    v = 26'sd233473;
      5'd4:    v = 26'sd117189;
      5'd5:    v = 26'sd58652;
      5'd6:    v = 26'sd29333;
      5'd7:    v = 26'sd14667;
      5'd8:    v = 26'sd7334;
      5'd9:    v = 26'sd3667;
      5'd10:   v = 26'sd1833;
      5'd11:   v = 26'sd917;
      5'd12:   v = 26'sd458;
      5'd13:   v = 26'sd229;
      5'd14:   v = 26'sd115;
      5'd15:   v = 26'sd57;
      5'd16:   v = 26'sd29;
      5'd17:   v = 26'sd14;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

  // Multiply list that builds Rz*Ry*Rx; TA = ca*sb and TB = sa*sb are
  // intermediate products. The entry m20 = -sb needs no multiply.
  function automatic mat_op_t mat_op(input logic [3:0] step);
    mat_op_t op;
    case (step)
      4'd0:    op = '{SRC_CA, SRC_CB, DST_M00, WB_SET};
      4'd1:    op = '{SRC_CA, SRC_SB, DST_TA,  WB_SET};
      4'd2:    op = '{SRC_SA, SRC_SB, DST_TB,  WB_SET};
      4'd3:    op = '{SRC_TA, SRC_SY, DST_M01, WB_SET};
      4'd4:    op = '{SRC_SA, SRC_CY, DST_M01, WB_SUB};
      4'd5:    op = '{SRC_TA, SRC_CY, DST_M02, WB_SET};
      4'd6:    op = '{SRC_SA, SRC_SY, DST_M02, WB_ADD};
      4'd7:    op = '{SRC_SA, SRC_CB, DST_M10, WB_SET};
      4'd8:    op = '{SRC_TB, SRC_SY, DST_M11, WB_SET};
      4'd9:    op = '{SRC_CA, SRC_CY, DST_M11, WB_ADD};
      4'd10:   op = '{SRC_TB, SRC_CY, DST_M12, WB_SET};
      4'd11:   op = '{SRC_CA, SRC_SY, DST_M12, WB_SUB};
      4'd12:   op = '{SRC_CB, SRC_SY, DST_M21, WB_SET};
      4'd13:   op = '{SRC_CB, SRC_CY, DST_M22, WB_SET};
      default: op = '{SRC_CA, SRC_CA, DST_M00, WB_SET};
    endcase
    return op;
  endfunction

endpackage

@@ rtl/euler_rigid_point_transform.sv @@
// ----------------------------------------------------------------------------
// Euler rigid point transform
// Maps each point p to Rz(yaw)*Ry(pitch)*Rx(roll)*p + t with saturation.
// ----------------------------------------------------------------------------
// One point enters per clock while point_stall is low; it passes through the
// five register stages (input register, partial products, row sums,
// rounding, offset and saturation) in order, and the pipeline stalls only
// where a later stage is full. The rotation matrix is rebuilt after
// reset and after every angle register write by one shared CORDIC unit
// and one shared multiplier, during which point_stall is high and
// cfg_ready is low. Offset writes take effect at once.
module euler_rigid_point_transform
  import ept_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       point_valid,
  output logic                       point_stall,
  input  point_t                     point,
  output logic                       result_valid,
  input  logic                       result_stall,
  output result_t                    result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int TF  = TRIG_FRAC_BITS;
  localparam int TW  = TF + 2;
  localparam int MW  = TF + 3;
  localparam int PW  = 2 * TW;
  localparam int CW  = COORD_WIDTH;
  localparam int H   = CW / 2;
  localparam int HW  = CW - H;
  localparam int PLW = MW + H + 1;
  localparam int PHW = MW + HW;
  localparam int SLW = PLW + 2;
  localparam int SHW = PHW + 2;
  localparam int AW  = MW + CW + 2;
  localparam int RS  = 30 - TF;

  localparam logic signed [CORDIC_W-1:0] CR_HALF   = (34'sd1 <<< RS) >>> 1;
  localparam logic signed [CORDIC_W-1:0] TRIG_ONE  = 34'sd1 <<< TF;
  localparam logic signed [CORDIC_W-1:0] TRIG_MONE = -(34'sd1 <<< TF);
  localparam logic signed [PW-1:0]       PROD_HALF = (PW'(1) <<< TF) >>> 1;
  localparam logic signed [AW-1:0]       ACC_HALF  = (AW'(1) <<< TF) >>> 1;
  localparam logic signed [AW-1:0]       COORD_MAX = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [AW-1:0]       COORD_MIN = {{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_ITER = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_MAT  = 3'd4;

  // Configuration registers.
  logic signed [ANG_WIDTH-1:0] yaw_angle, pitch_angle, roll_angle;
  logic signed [CW-1:0]        offset_x, offset_y, offset_z;

  // Rebuild sequencer state.
  logic [2:0] state;
  logic [1:0] ang_sel;
  logic [4:0] iter;
  logic [3:0] mstep;
  logic       cfg_write;
  logic       angle_write;

  // CORDIC datapath.
  logic signed [CORDIC_W-1:0]  cx, cy_r, cx_next, cy_next;
  logic signed [CORDIC_ZW-1:0] cz, cz_next, z_load, atn;
  logic                        cneg, neg_load;
  logic signed [ANG_WIDTH-1:0] ang_cur;
  logic signed [17:0]          r1, r2, r3;
  logic signed [CORDIC_W-1:0]  xr, yr, xc, yc, cos_v, sin_v;

  // Trig values, intermediate products and the matrix.
  logic signed [TW-1:0] ca, sa, cb, sb, cy, sy, ta, tb;
  logic signed [MW-1:0] rot [0:8];
  mat_op_t              op;
  logic signed [TW-1:0] opa, opb;
  logic signed [PW-1:0] prod, prod_rnd;
  logic signed [MW-1:0] wb_val, wb_cur;
  logic                 wb_valid;
  logic [3:0]           wb_dest;
  logic [1:0]           wb_mode;

  // Pipeline.
  logic                 v1, v2, v3, v4;
  logic                 rdy1, rdy2, rdy3, rdy4, rdy5;
  logic                 point_accept;
  logic signed [CW-1:0] p1 [0:2];
  logic signed [PLW-1:0] prod_lo [0:2][0:2];
  logic signed [PHW-1:0] prod_hi [0:2][0:2];
  logic signed [SLW-1:0] sum_lo [0:2];
  logic signed [SHW-1:0] sum_hi [0:2];
  logic signed [AW-1:0]  rrow [0:2];
  logic signed [CW-1:0]  crd [0:2];
  logic [2:0]            row_sat;

  assign cfg_ready   = (state == ST_IDLE);
  assign cfg_write   = cfg_valid && cfg_ready;
  assign angle_write = cfg_write && (cfg_index <= REG_ROLL);

  // Configuration register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_angle   <= '0;
      pitch_angle <= '0;
      roll_angle  <= '0;
      offset_x    <= '0;
      offset_y    <= '0;
      offset_z    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_YAW:      yaw_angle   <= cfg_data[ANG_WIDTH-1:0];
        REG_PITCH:    pitch_angle <= cfg_data[ANG_WIDTH-1:0];
        REG_ROLL:     roll_angle  <= cfg_data[ANG_WIDTH-1:0];
        REG_OFFSET_X: offset_x    <= cfg_data[CW-1:0];
        REG_OFFSET_Y: offset_y    <= cfg_data[CW-1:0];
        REG_OFFSET_Z: offset_z    <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Angle reduction to +-90 degrees with a sign flag for the folded half.
  always_comb begin
    case (ang_sel)
      2'd0:    ang_cur = yaw_angle;
      2'd1:    ang_cur = pitch_angle;
      default: ang_cur = roll_angle;
    endcase
    r1 = {ang_cur[ANG_WIDTH-1], ang_cur};
    if (r1 >= DEG360) begin
      r1 = r1 - DEG360;
    end else if (r1 <= DEG360_NEG) begin
      r1 = r1 + DEG360;
    end
    r2 = r1;
    if (r1 >= DEG180) begin
      r2 = r1 - DEG360;
    end else if (r1 < DEG180_NEG) begin
      r2 = r1 + DEG360;
    end
    r3       = r2;
    neg_load = 1'b0;
    if (r2 > DEG90) begin
      r3       = r2 - DEG180;
      neg_load = 1'b1;
    end else if (r2 < DEG90_NEG) begin
      r3       = r2 + DEG180;
      neg_load = 1'b1;
    end
    z_load = {r3, 8'd0};
  end

  // One CORDIC rotation step.
  always_comb begin
    atn = cordic_atan(iter);
    if (cz >= 0) begin
      cx_next = cx - (cy_r >>> iter);
      cy_next = cy_r + (cx >>> iter);
      cz_next = cz - atn;
    end else begin
      cx_next = cx + (cy_r >>> iter);
      cy_next = cy_r - (cx >>> iter);
      cz_next = cz + atn;
    end
  end

  // Round the CORDIC outputs to the trig format, clamp to +-1, undo the fold.
  always_comb begin
    xr = (cx + CR_HALF) >>> RS;
    yr = (cy_r + CR_HALF) >>> RS;
    xc = (xr > TRIG_ONE) ? TRIG_ONE : ((xr < TRIG_MONE) ? TRIG_MONE : xr);
    yc = (yr > TRIG_ONE) ? TRIG_ONE : ((yr < TRIG_MONE) ? TRIG_MONE : yr);
    cos_v = cneg ? -xc : xc;
    sin_v = cneg ? -yc : yc;
  end

  // Operand selection for the shared matrix multiplier.
  always_comb begin
    op = mat_op(mstep);
    case (op.src_a)
      SRC_CA:  opa = ca;
      SRC_SA:  opa = sa;
      SRC_CB:  opa = cb;
      SRC_SB:  opa = sb;
      SRC_CY:  opa = cy;
      SRC_SY:  opa = sy;
      SRC_TA:  opa = ta;
      default: opa = tb;
    endcase
    case (op.src_b)
      SRC_CA:  opb = ca;
      SRC_SA:  opb = sa;
      SRC_CB:  opb = cb;
      SRC_SB:  opb = sb;
      SRC_CY:  opb = cy;
      SRC_SY:  opb = sy;
      SRC_TA:  opb = ta;
      default: opb = tb;
    endcase
  end

  // Product rounding half up and the destination's running value.
  always_comb begin
    prod_rnd = (prod + PROD_HALF) >>> TF;
    wb_val   = prod_rnd[MW-1:0];
    wb_cur   = rot[wb_dest];
  end

  // Rebuild sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      ang_sel  <= 2'd0;
      iter     <= '0;
      mstep    <= '0;
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= (state == ST_MAT) && (mstep != 4'(MAT_OPS));
      case (state)
        ST_IDLE: begin
          if (angle_write) begin
            state   <= ST_LOAD;
            ang_sel <= 2'd0;
          end
        end
        ST_LOAD: begin
          iter  <= '0;
          state <= ST_ITER;
        end
        ST_ITER: begin
          if (iter == 5'(CORDIC_STEPS - 1)) begin
            state <= ST_FIN;
          end else begin
            iter <= iter + 5'd1;
          end
        end
        ST_FIN: begin
          if (ang_sel == 2'd2) begin
            mstep <= '0;
            state <= ST_MAT;
          end else begin
            ang_sel <= ang_sel + 2'd1;
            state   <= ST_LOAD;
          end
        end
        ST_MAT: begin
          if (mstep == 4'(MAT_OPS)) begin
            state <= ST_IDLE;
          end else begin
            mstep <= mstep + 4'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Rebuild datapath: CORDIC registers, trig values, multiplier, write-back.
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      cx   <= CORDIC_GAIN;
      cy_r <= '0;
      cz   <= z_load;
      cneg <= neg_load;
    end else if (state == ST_ITER) begin
      cx   <= cx_next;
      cy_r <= cy_next;
      cz   <= cz_next;
    end
    if (state == ST_FIN) begin
      case (ang_sel)
        2'd0: begin
          ca <= cos_v[TW-1:0];
          sa <= sin_v[TW-1:0];
        end
        2'd1: begin
          cb <= cos_v[TW-1:0];
          sb <= sin_v[TW-1:0];
        end
        default: begin
          cy <= cos_v[TW-1:0];
          sy <= sin_v[TW-1:0];
        end
      endcase
    end
    prod    <= opa * opb;
    wb_dest <= op.dest;
    wb_mode <= op.mode;
    if (wb_valid) begin
      if (wb_dest == DST_TA) begin
        ta <= wb_val[TW-1:0];
      end else if (wb_dest == DST_TB) begin
        tb <= wb_val[TW-1:0];
      end else begin
        case (wb_mode)
          WB_ADD:  rot[wb_dest] <= wb_cur + wb_val;
          WB_SUB:  rot[wb_dest] <= wb_cur - wb_val;
          default: rot[wb_dest] <= wb_val;
        endcase
      end
    end
    if (state == ST_MAT && mstep == 4'(MAT_OPS)) begin
      rot[DST_M20] <= -MW'(sb);
    end
  end

  // Pipeline flow control: a stage advances when it is empty or drains.
  assign rdy5         = !result_valid || !result_stall;
  assign rdy4         = !v4 || rdy5;
  assign rdy3         = !v3 || rdy4;
  assign rdy2         = !v2 || rdy3;
  assign rdy1         = !v1 || rdy2;
  assign point_stall  = (state != ST_IDLE) || !rdy1;
  assign point_accept = point_valid && !point_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= point_accept;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) result_valid <= v4;
    end
  end

  // Stage 1: input register.
  always_ff @(posedge clk) begin
    if (point_accept) begin
      p1[0] <= point.point_x;
      p1[1] <= point.point_y;
      p1[2] <= point.point_z;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    // Stage 2: partial products of each matrix entry with both coordinate halves.
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (v1 && rdy2) begin
          prod_lo[r][c] <= rot[r*3+c] * $signed({1'b0, p1[c][H-1:0]});
          prod_hi[r][c] <= rot[r*3+c] * $signed(p1[c][CW-1:H]);
        end
      end
    end

    // Stage 3: row sums of the low and high partial products.
    always_ff @(posedge clk) begin
      if (v2 && rdy3) begin
        sum_lo[r] <= SLW'(prod_lo[r][0]) + SLW'(prod_lo[r][1]) + SLW'(prod_lo[r][2]);
        sum_hi[r] <= SHW'(prod_hi[r][0]) + SHW'(prod_hi[r][1]) + SHW'(prod_hi[r][2]);
      end
    end

    // Stage 4: recombine the halves and round half up to 8 fraction bits.
    always_ff @(posedge clk) begin
      if (v3 && rdy4) begin
        rrow[r] <= ((AW'(sum_hi[r]) <<< H) + AW'(sum_lo[r]) + ACC_HALF) >>> TF;
      end
    end

    // Stage 5 logic: add the offset and saturate to the coordinate range.
    logic signed [AW-1:0] off_ext, vsum;
    always_comb begin
      off_ext = (r == 0) ? AW'(offset_x) : ((r == 1) ? AW'(offset_y) : AW'(offset_z));
      vsum    = rrow[r] + off_ext;
      if (vsum > COORD_MAX) begin
        crd[r]     = COORD_MAX[CW-1:0];
        row_sat[r] = 1'b1;
      end else if (vsum < COORD_MIN) begin
        crd[r]     = COORD_MIN[CW-1:0];
        row_sat[r] = 1'b1;
      end else begin
        crd[r]     = vsum[CW-1:0];
        row_sat[r] = 1'b0;
      end
    end
  end

  // Stage 5: output register.
  always_ff @(posedge clk) begin
    if (v4 && rdy5) begin
      result.out_x     <= crd[0];
      result.out_y     <= crd[1];
      result.out_z     <= crd[2];
      result.saturated <= |row_sat;
    end
  end

endmodule

@@ rtl/ept_checker.sv @@
// ----------------------------------------------------------------------------
// Rigid point transform port checker
// Watches the top-level ports for rebuild blocking and result hold behavior.
// ----------------------------------------------------------------------------
module ept_checker
  import ept_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       point_valid,
  input logic                       point_stall,
  input point_t                     point,
  input logic                       result_valid,
  input logic                       result_stall,
  input result_t                    result,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  // Reset starts a matrix rebuild, which blocks points and configuration.
  a_reset_rebuild: assert property (@(posedge clk)
    rst |=> (point_stall && !cfg_ready))
    else $error("no rebuild after reset");

  // An angle write starts a rebuild in the next cycle.
  a_angle_rebuild: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == REG_YAW || cfg_index == REG_PITCH ||
     cfg_index == REG_ROLL)) |=> (point_stall && !cfg_ready))
    else $error("angle write did not start a rebuild");

  // A stalled result transaction holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind euler_rigid_point_transform ept_checker u_ept_checker (.*);
